// File: src/sqrq_pkg.sv
// Package for the int8 square requantize core.
// Holds the configuration record, register index codes and pipeline depth.
// Depends on nothing; every module of the core imports it.
`timescale 1ns / 1ps
`default_nettype none

package sqrq_pkg;

  localparam int unsigned NumStages  = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_OFFSET  = 3'd0,
    REG_OUT_OFFSET = 3'd1,
    REG_PRE_SHIFT  = 3'd2,
    REG_MULTIPLIER = 3'd3,
    REG_POST_SHIFT = 3'd4,
    REG_ACT_MIN    = 3'd5,
    REG_ACT_MAX    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [8:0] in_offset;
    logic signed [7:0] out_offset;
    logic [3:0]        pre_shift;
    logic [30:0]       multiplier;
    logic [4:0]        post_shift;
    logic signed [7:0] act_min;
    logic signed [7:0] act_max;
  } cfg_t;

  localparam logic [30:0] MultReset = 31'h4000_0000;
  localparam logic [30:0] SatMax    = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

// File: src/sqrq_cfg_regs.sv
// Configuration register file of the int8 square requantize core.
// Decodes plain index writes into the cfg_t record; uses sqrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqrq_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sqrq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sqrq_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sqrq_pkg::cfg_t                    cfg_o
);
  import sqrq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IN_OFFSET:  cfg_d.in_offset  = cfg_wdata_i[8:0];
        REG_OUT_OFFSET: cfg_d.out_offset = cfg_wdata_i[7:0];
        REG_PRE_SHIFT:  cfg_d.pre_shift  = cfg_wdata_i[3:0];
        REG_MULTIPLIER: cfg_d.multiplier = cfg_wdata_i[30:0];
        REG_POST_SHIFT: cfg_d.post_shift = cfg_wdata_i[4:0];
        REG_ACT_MIN:    cfg_d.act_min    = cfg_wdata_i[7:0];
        REG_ACT_MAX:    cfg_d.act_max    = cfg_wdata_i[7:0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_offset  <= '0;
      cfg_q.out_offset <= '0;
      cfg_q.pre_shift  <= '0;
      cfg_q.multiplier <= MultReset;
      cfg_q.post_shift <= '0;
      cfg_q.act_min    <= 8'sh80;
      cfg_q.act_max    <= 8'sh7F;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/sqrq_square.sv
// Front stages of the int8 square requantize core: offset add and square,
// then left shift with saturation to 31 bits. Uses sqrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqrq_square (
  input  wire logic              clk_i,
  input  wire logic [1:0]        en_i,
  input  wire sqrq_pkg::cfg_t    cfg_i,
  input  wire logic signed [7:0] sample_i,
  output logic [30:0]            shifted_o
);
  import sqrq_pkg::*;

  logic signed [9:0]  offs_sum;
  logic signed [19:0] prod_sq;
  logic [17:0]        sq_q, sq_d;
  logic [32:0]        wide_shift;
  logic [30:0]        sat_q, sat_d;

  always_comb begin
    offs_sum  = 10'(sample_i) + 10'(cfg_i.in_offset);
    prod_sq   = offs_sum * offs_sum;
    sq_d      = prod_sq[17:0];
    wide_shift = {15'd0, sq_q} << cfg_i.pre_shift;
    sat_d     = (wide_shift[32:31] != 2'b00) ? SatMax : wide_shift[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q <= sq_d;
    end
    if (en_i[1]) begin
      sat_q <= sat_d;
    end
  end

  assign shifted_o = sat_q;

endmodule

`default_nettype wire

// File: src/sqrq_rescale.sv
// Rescale stages of the int8 square requantize core: Q31 multiply, rounding
// high half, then rounding right shift. Uses sqrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqrq_rescale (
  input  wire logic           clk_i,
  input  wire logic [2:0]     en_i,
  input  wire sqrq_pkg::cfg_t cfg_i,
  input  wire logic [30:0]    shifted_i,
  output logic [31:0]         scaled_o
);
  import sqrq_pkg::*;

  logic [61:0] prod_q, prod_d;
  logic [61:0] nudged;
  logic [30:0] hi_q, hi_d;
  logic [31:0] hi_ext;
  logic        round_bit;
  logic [31:0] rnd_q, rnd_d;

  always_comb begin
    prod_d    = {31'd0, shifted_i} * {31'd0, cfg_i.multiplier};
    nudged    = prod_q + 62'h4000_0000;
    hi_d      = nudged[61:31];
    hi_ext    = {hi_q, 1'b0};
    round_bit = hi_ext[cfg_i.post_shift];
    rnd_d     = ({1'b0, hi_q} >> cfg_i.post_shift) + {31'd0, round_bit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      hi_q <= hi_d;
    end
    if (en_i[2]) begin
      rnd_q <= rnd_d;
    end
  end

  assign scaled_o = rnd_q;

endmodule

`default_nettype wire

// File: src/sqrq_clamp.sv
// Output stage of the int8 square requantize core: zero point add and clamp
// to the activation range into the output register. Uses sqrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqrq_clamp (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire sqrq_pkg::cfg_t cfg_i,
  input  wire logic [31:0]    scaled_i,
  output logic signed [7:0]   squared_o
);
  import sqrq_pkg::*;

  logic signed [33:0] sum;
  logic signed [33:0] lo_ext, hi_ext;
  logic signed [7:0]  res_q, res_d;

  always_comb begin
    sum    = $signed({2'b00, scaled_i}) + 34'(cfg_i.out_offset);
    lo_ext = 34'(cfg_i.act_min);
    hi_ext = 34'(cfg_i.act_max);
    if (sum > hi_ext) begin
      res_d = cfg_i.act_max;
    end else if (sum < lo_ext) begin
      res_d = cfg_i.act_min;
    end else begin
      res_d = sum[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign squared_o = res_q;

endmodule

`default_nettype wire

// File: src/int8_square_requantize_core.sv
// Top level of the int8 square requantize core: valid chain and stage enables.
// Instantiates sqrq_cfg_regs, sqrq_square, sqrq_rescale, sqrq_clamp; uses sqrq_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   sample_i
//   out      source     out_valid_o / out_stall_i squared_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One sample enters per cycle while in_stall_o is low.
// The six stages are: add+square, shift+saturate, 31x31 multiply, nudge,
// rounding shift, offset+clamp into the output register.
// A stall holds each occupied stage with no empty stage after it; empty stages still fill, closing bubbles.
// Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module int8_square_requantize_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [7:0]            sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [7:0]                 squared_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [sqrq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sqrq_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sqrq_pkg::*;

  cfg_t                 cfg;
  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] en;
  logic [30:0]          shifted;
  logic [31:0]          scaled;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  sqrq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sqrq_square u_square (
    .clk_i     (clk_i),
    .en_i      (en[1:0]),
    .cfg_i     (cfg),
    .sample_i  (sample_i),
    .shifted_o (shifted)
  );

  sqrq_rescale u_rescale (
    .clk_i     (clk_i),
    .en_i      (en[4:2]),
    .cfg_i     (cfg),
    .shifted_i (shifted),
    .scaled_o  (scaled)
  );

  sqrq_clamp u_clamp (
    .clk_i     (clk_i),
    .en_i      (en[5]),
    .cfg_i     (cfg),
    .scaled_i  (scaled),
    .squared_o (squared_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a stage is empty");

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although the output drains");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted request missing from first stage");

  a_stalled_out_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && out_valid_o && out_stall_i) |=> vld_q[NumStages-2])
    else $error("stage dropped while output stalled");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for int8_square_requantize_core: random and directed samples
// under many register settings, results compared against a local requantize model.
// Depends on sqrq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import sqrq_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [7:0]   sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [7:0]   squared;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  cfg_t                shadow_cfg;
  logic signed [7:0]   sample_q[$];
  logic signed [7:0]   want_squared_q[$];
  logic signed [7:0]   want_val;
  bit                  quiet = 1'b0;
  int                  in_gap;
  int                  stall_left;
  int                  stall_draw;
  int                  errors = 0;
  int                  taken_cnt = 0;
  int                  result_cnt = 0;
  int                  setting_cnt = 0;

  int8_square_requantize_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .sample_i   (sample),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .squared_o  (squared),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  function automatic logic signed [7:0] square_requant(logic signed [7:0] s, cfg_t c);
    longint        centered;
    longint        scaled;
    longint unsigned sq;
    longint unsigned prod;
    longint unsigned hi;
    longint unsigned mask;
    longint unsigned q;
    centered = longint'(s) + longint'($signed(c.in_offset));
    sq = longint'(centered * centered) << c.pre_shift;
    if (sq > 64'h7FFF_FFFF) sq = 64'h7FFF_FFFF;
    prod = sq * longint'(c.multiplier);
    hi = (prod + (64'd1 << 30)) >> 31;
    mask = (64'd1 << c.post_shift) - 64'd1;
    q = (hi >> c.post_shift) + (((hi & mask) > (mask >> 1)) ? 64'd1 : 64'd0);
    scaled = longint'(q) + longint'($signed(c.out_offset));
    if (scaled > longint'($signed(c.act_max))) scaled = longint'($signed(c.act_max));
    else if (scaled < longint'($signed(c.act_min))) scaled = longint'($signed(c.act_min));
    return scaled[7:0];
  endfunction

  function automatic cfg_t make_setting(int in_off, int out_off, int pre, int mult, int post,
                                        int amin, int amax);
    cfg_t c;
    c.in_offset  = 9'(in_off);
    c.out_offset = 8'(out_off);
    c.pre_shift  = 4'(pre);
    c.multiplier = 31'(mult);
    c.post_shift = 5'(post);
    c.act_min    = 8'(amin);
    c.act_max    = 8'(amax);
    return c;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.in_offset  = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                               : 9'($urandom_range(0, 256) - 128);
    c.out_offset = 8'($urandom);
    c.pre_shift  = 4'($urandom);
    case ($urandom_range(0, 7))
      0:       c.multiplier = SatMax;
      1:       c.multiplier = '0;
      default: c.multiplier = 31'($urandom);
    endcase
    c.post_shift = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(14, 31));
    case ($urandom_range(0, 5))
      0: begin
        c.act_min = 8'(-128);
        c.act_max = 8'(127);
      end
      1: begin
        c.act_min = 8'($urandom);
        c.act_max = 8'($urandom);
      end
      default: begin
        c.act_min = 8'($urandom_range(0, 127) - 128);
        c.act_max = 8'($urandom_range(0, 127));
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_IN_OFFSET:  shadow_cfg.in_offset  = data[8:0];
      REG_OUT_OFFSET: shadow_cfg.out_offset = data[7:0];
      REG_PRE_SHIFT:  shadow_cfg.pre_shift  = data[3:0];
      REG_MULTIPLIER: shadow_cfg.multiplier = data[30:0];
      REG_POST_SHIFT: shadow_cfg.post_shift = data[4:0];
      REG_ACT_MIN:    shadow_cfg.act_min    = data[7:0];
      REG_ACT_MAX:    shadow_cfg.act_max    = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input cfg_t c);
    write_reg(REG_IN_OFFSET,  {22'd0, c.in_offset});
    write_reg(REG_OUT_OFFSET, {23'd0, c.out_offset});
    write_reg(REG_PRE_SHIFT,  {27'd0, c.pre_shift});
    write_reg(REG_MULTIPLIER, c.multiplier);
    write_reg(REG_POST_SHIFT, {26'd0, c.post_shift});
    write_reg(REG_ACT_MIN,    {23'd0, c.act_min});
    write_reg(REG_ACT_MAX,    {23'd0, c.act_max});
    setting_cnt++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid || want_squared_q.size() != 0) @(negedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("int8_square_requantize_core test failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sample   <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        want_squared_q.push_back(square_requant(sample, shadow_cfg));
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          sample   <= sample_q.pop_front();
          in_gap   <= quiet ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (want_squared_q.size() == 0) begin
        $error("squared: result %0d with no request pending", squared);
        errors++;
      end else begin
        want_val = want_squared_q.pop_front();
        if (squared !== want_val) begin
          $error("squared: expected %0d, actual %0d", want_val, squared);
          errors++;
        end
      end
      result_cnt++;
      stall_draw = quiet ? 0 : $urandom_range(0, 5);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  initial begin
    shadow_cfg = make_setting(0, 0, 0, MultReset, 0, -128, 127);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sample_q.push_back(-128);
    sample_q.push_back(127);
    sample_q.push_back(0);
    sample_q.push_back(1);
    sample_q.push_back(-1);
    sample_q.push_back(2);
    settle();

    // saturate the shifted square, widest multiplier and shift
    apply_setting(make_setting(255, -128, 15, SatMax, 31, -128, 127));
    sample_q.push_back(127);
    sample_q.push_back(-128);
    sample_q.push_back(-1);
    settle();

    // inverted clamp range; spare index must be dropped
    apply_setting(make_setting(0, -128, 0, MultReset, 0, 100, -100));
    write_reg(RegSpare, '1);
    sample_q.push_back(0);
    sample_q.push_back(10);
    sample_q.push_back(14);
    sample_q.push_back(127);
    settle();

    apply_setting(make_setting(-256, 127, 0, SatMax, 10, -128, 127));
    sample_q.push_back(-128);
    sample_q.push_back(127);
    sample_q.push_back(0);
    settle();

    // ties round away from zero
    apply_setting(make_setting(0, 0, 0, MultReset, 1, -128, 127));
    sample_q.push_back(1);
    sample_q.push_back(3);
    sample_q.push_back(5);
    sample_q.push_back(-7);
    settle();

    apply_setting(make_setting(128, 127, 0, 0, 31, -128, 127));
    sample_q.push_back(-128);
    sample_q.push_back(127);
    settle();

    for (int p = 0; p < 15; p++) begin
      apply_setting(random_setting());
      if ($urandom_range(0, 1) == 1) write_reg(RegSpare, 31'($urandom));
      quiet = (p % 4 == 3);
      repeat (70) sample_q.push_back(8'($urandom));
      settle();
    end

    $display("Checked %0d results from %0d samples across %0d register settings.",
             result_cnt, taken_cnt, setting_cnt);
    if (want_squared_q.size() != 0) begin
      $error("squared: %0d results never arrived", want_squared_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("int8_square_requantize_core test passed");
    end else begin
      $display("int8_square_requantize_core test failed");
    end
    $finish;
  end

endmodule

// File: int8_square_requantize_core.f
src/sqrq_pkg.sv
src/sqrq_cfg_regs.sv
src/sqrq_square.sv
src/sqrq_rescale.sv
src/sqrq_clamp.sv
src/int8_square_requantize_core.sv
tb/sv/tb.sv
